// ===== sv/ssd_pkg.sv =====
// Shared types, constants and address helper for the sensor stuck detector.
`default_nettype none

package ssd_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int VALUE_BITS   = 32;

    localparam int IN_VALUE_BITS = 32;
    localparam int LIMIT_BITS    = 31;
    localparam int NUM_VEC       = 3;
    localparam int NUM_SCA       = 5;
    localparam int NUM_SENS      = NUM_VEC + NUM_SCA;
    localparam int NUM_AXES      = 3;
    localparam int NUM_CHAN      = NUM_VEC * NUM_AXES + NUM_SCA;
    localparam int SENS_BITS     = $clog2(NUM_SENS);
    localparam int AXIS_BITS     = $clog2(NUM_AXES);
    localparam int CHAN_BITS     = $clog2(NUM_CHAN);
    localparam int POS_BITS      = $clog2(WINDOW_DEPTH);
    localparam int FILL_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int MEM_DEPTH     = NUM_CHAN * WINDOW_DEPTH;
    localparam int ADDR_BITS     = $clog2(MEM_DEPTH);
    localparam int SPAN_BITS     = VALUE_BITS + 1;
    localparam int CMP_BITS      = (SPAN_BITS > LIMIT_BITS) ? SPAN_BITS : LIMIT_BITS;
    localparam int MODE_BITS     = 2;
    localparam int USER_BITS     = MODE_BITS + SENS_BITS;
    localparam int IN_DATA_BITS  = NUM_AXES * IN_VALUE_BITS;
    localparam int CFG_IDX_BITS  = 2;

    // Sensor that gates its sample on a positive reading
    localparam logic [SENS_BITS-1:0] SENSOR_RANGE = SENS_BITS'(6);

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [SPAN_BITS-1:0]  t_span;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_PUSH   = 2'd1,
        MODE_EVAL   = 2'd2,
        MODE_REPORT = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LIMIT_VECTOR = 2'd0,
        CFG_LIMIT_SCALAR = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_EV_RD,
        ST_EV_ACC,
        ST_EV_SPAN,
        ST_REPORT
    } t_state;

    // Ring memory address of one entry of one channel
    function automatic logic [ADDR_BITS-1:0] ring_addr(
        input logic [CHAN_BITS-1:0] chan,
        input logic [POS_BITS-1:0]  pos
    );
        logic [ADDR_BITS-1:0] base;
        base = ADDR_BITS'(chan) * ADDR_BITS'(WINDOW_DEPTH);
        return base + ADDR_BITS'(pos);
    endfunction

endpackage

`default_nettype wire

// ===== sv/sensor_stuck_detector.sv =====
// Top level of the sensor stuck detector: ring memory, sequencer and shared min/max unit.
//
// Input channel (i_s_*): one item per handshake; tuser carries mode and sensor,
// tdata the three signed axis values. Modes: sample stores a sensor's latest
// value, push writes all 14 latest channel values into their rings through
// the single memory write port, evaluate walks the ring memory one entry per
// read plus update step and one span compare per channel, then the report
// step hands the mask to the output register; report just hands the stored
// mask over. The single ring memory port and the one min/max unit make these
// steps run one after another.
// Output channel (o_m_*): one 8-bit health mask per evaluate or report item,
// held in an output register; a new input item is taken while it waits.
// If the receiver stalls, a finished mask waits in the report step and no new
// item is taken until the register frees up.
// Configuration channel (i_cfg_*): writes to the two limit registers, always
// ready; write it only while no item is in flight.
// Reset clears state, latest values, ring positions, fill count, stored mask
// and sets the limits to 0 (vector) and 1 (scalar). Ring contents need no clear.
`default_nettype none

module sensor_stuck_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tuser: mode[1:0], sensor[4:2]
    input  wire logic [ssd_pkg::USER_BITS-1:0]      i_s_tuser,
    // tdata: value_x[31:0], value_y[63:32], value_z[95:64]
    input  wire logic [ssd_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: health[7:0]
    output logic [ssd_pkg::NUM_SENS-1:0]            o_m_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ssd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ssd_pkg::LIMIT_BITS-1:0]     i_cfg_data
);
    import ssd_pkg::*;

    t_state                 r_state, n_state;
    logic [CHAN_BITS-1:0]   r_chan, n_chan;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [SENS_BITS-1:0]   r_sens, n_sens;
    logic [AXIS_BITS-1:0]   r_axis, n_axis;
    logic [POS_BITS-1:0]    r_wpos, n_wpos;
    logic [FILL_BITS-1:0]   r_fill, n_fill;
    logic [NUM_SENS-1:0]    r_flat, n_flat;
    logic [NUM_SENS-1:0]    r_health, n_health;
    logic [NUM_SENS-1:0]    r_out_data, n_out_data;
    logic                   r_out_valid, n_out_valid;
    t_value                 r_lo, n_lo;
    t_value                 r_hi, n_hi;
    logic [LIMIT_BITS-1:0]  r_lim_vec, r_lim_sca;
    t_value                 r_latest [NUM_CHAN];
    t_value                 r_rd_data;
    t_value                 mem [MEM_DEPTH];

    logic                   s_accept;
    t_mode                  in_mode;
    logic [SENS_BITS-1:0]   in_sensor;
    t_value                 in_x, in_y, in_z;
    logic [CHAN_BITS-1:0]   vec_base;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
    t_span                  span;
    logic [CMP_BITS-1:0]    span_u;
    logic                   full;
    logic                   axis_flat;

    assign in_mode   = t_mode'(i_s_tuser[MODE_BITS-1:0]);
    assign in_sensor = i_s_tuser[USER_BITS-1:MODE_BITS];
    assign in_x      = t_value'($signed(i_s_tdata[IN_VALUE_BITS-1:0]));
    assign in_y      = t_value'($signed(i_s_tdata[2*IN_VALUE_BITS-1:IN_VALUE_BITS]));
    assign in_z      = t_value'($signed(i_s_tdata[3*IN_VALUE_BITS-1:2*IN_VALUE_BITS]));
    assign vec_base  = CHAN_BITS'(in_sensor) * CHAN_BITS'(NUM_AXES);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign full    = (r_fill == FILL_BITS'(WINDOW_DEPTH));
    assign wr_addr = ring_addr(r_chan, r_wpos);
    assign rd_addr = ring_addr(r_chan, r_pos);
    assign mem_we  = (r_state == ST_PUSH);

    // Shared span unit: exact difference, then limit compare
    assign span   = t_span'(r_hi) - t_span'(r_lo);
    assign span_u = CMP_BITS'(unsigned'(span));
    assign axis_flat = (r_sens < SENS_BITS'(NUM_VEC))
                     ? (span_u <= CMP_BITS'(r_lim_vec))
                     : (span_u <  CMP_BITS'(r_lim_sca));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_latest[r_chan];
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_vec <= '0;
            r_lim_sca <= LIMIT_BITS'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LIMIT_VECTOR) begin
                r_lim_vec <= i_cfg_data;
            end else if (i_cfg_index == CFG_LIMIT_SCALAR) begin
                r_lim_sca <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_latest[i] <= '0;
            end
        end else if (s_accept && in_mode == MODE_SAMPLE) begin
            if (in_sensor < SENS_BITS'(NUM_VEC)) begin
                r_latest[vec_base]                  <= in_x;
                r_latest[vec_base + CHAN_BITS'(1)]  <= in_y;
                r_latest[vec_base + CHAN_BITS'(2)]  <= in_z;
            end else if (in_sensor != SENSOR_RANGE ||
                         (!in_x[VALUE_BITS-1] && in_x != '0)) begin
                // drop a downward range reading that is not positive
                r_latest[CHAN_BITS'(in_sensor) + CHAN_BITS'(NUM_VEC * (NUM_AXES - 1))] <= in_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chan      <= '0;
            r_pos       <= '0;
            r_sens      <= '0;
            r_axis      <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_flat      <= '0;
            r_health    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_pos       <= n_pos;
            r_sens      <= n_sens;
            r_axis      <= n_axis;
            r_wpos      <= n_wpos;
            r_fill      <= n_fill;
            r_flat      <= n_flat;
            r_health    <= n_health;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
    end

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_pos       = r_pos;
        n_sens      = r_sens;
        n_axis      = r_axis;
        n_wpos      = r_wpos;
        n_fill      = r_fill;
        n_flat      = r_flat;
        n_health    = r_health;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_lo        = r_lo;
        n_hi        = r_hi;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_mode)
                        MODE_PUSH: begin
                            n_state = ST_PUSH;
                            n_chan  = '0;
                        end
                        MODE_EVAL: begin
                            n_state = ST_EV_RD;
                            n_chan  = '0;
                            n_pos   = '0;
                            n_sens  = '0;
                            n_axis  = '0;
                            n_flat  = '1;
                        end
                        MODE_REPORT: begin
                            n_state = ST_REPORT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                if (r_chan == CHAN_BITS'(NUM_CHAN - 1)) begin
                    n_state = ST_IDLE;
                    n_wpos  = (r_wpos == POS_BITS'(WINDOW_DEPTH - 1))
                            ? '0 : r_wpos + POS_BITS'(1);
                    if (!full) begin
                        n_fill = r_fill + FILL_BITS'(1);
                    end
                end else begin
                    n_chan = r_chan + CHAN_BITS'(1);
                end
            end
            ST_EV_RD: begin
                n_state = ST_EV_ACC;
            end
            ST_EV_ACC: begin
                if (r_pos == '0) begin
                    n_lo = r_rd_data;
                    n_hi = r_rd_data;
                end else begin
                    if (r_rd_data < r_lo) begin
                        n_lo = r_rd_data;
                    end
                    if (r_rd_data > r_hi) begin
                        n_hi = r_rd_data;
                    end
                end
                if (r_pos == POS_BITS'(WINDOW_DEPTH - 1)) begin
                    n_state = ST_EV_SPAN;
                end else begin
                    n_pos   = r_pos + POS_BITS'(1);
                    n_state = ST_EV_RD;
                end
            end
            ST_EV_SPAN: begin
                n_flat[r_sens] = r_flat[r_sens] && axis_flat;
                if (r_chan == CHAN_BITS'(NUM_CHAN - 1)) begin
                    // stuck only when the ring is full and every axis is flat
                    n_health = ~(n_flat & {NUM_SENS{full}});
                    n_state  = ST_REPORT;
                end else begin
                    n_chan  = r_chan + CHAN_BITS'(1);
                    n_pos   = '0;
                    n_state = ST_EV_RD;
                    if (r_sens < SENS_BITS'(NUM_VEC) &&
                        r_axis != AXIS_BITS'(NUM_AXES - 1)) begin
                        n_axis = r_axis + AXIS_BITS'(1);
                    end else begin
                        n_axis = '0;
                        n_sens = r_sens + SENS_BITS'(1);
                    end
                end
            end
            ST_REPORT: begin
                // hold the mask until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_health;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(WINDOW_DEPTH))
        else $error("fill count above ring depth");

    a_wpos_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (FILL_BITS'(r_wpos) == r_fill))
        else $error("write position out of step with fill count");

    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_mode == MODE_EVAL) |=> (r_state == ST_EV_RD && r_chan == '0))
        else $error("evaluate did not start at the first channel");

    a_span_last_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EV_SPAN) |-> (r_pos == POS_BITS'(WINDOW_DEPTH - 1)))
        else $error("span taken before the whole ring was read");

endmodule

`default_nettype wire
